// ----- hdl/ethernet_frame_checker_assert.svh -----
// Assertion macros for the Ethernet frame checker.
// Used by modules that have i_clk and i_rst_n in scope; empty under SYNTHESIS.
`ifndef ETHERNET_FRAME_CHECKER_ASSERT_SVH
`define ETHERNET_FRAME_CHECKER_ASSERT_SVH

`ifndef SYNTHESIS

// Condition on the same edge
`define EFC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("efc assertion failed");

// Condition on the following edge
`define EFC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("efc assertion failed");

`else

`define EFC_ASSERT_IMPL(lbl, ante, cons)
`define EFC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- hdl/efc_pkg.sv -----
// Shared types, constants and the CRC-32 byte update for the frame checker.
// No dependencies.
package efc_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int COUNT_W             = 12;

    // Byte positions in the raw frame
    localparam logic [COUNT_W-1:0] POS_SFD      = 12'd7;
    localparam logic [COUNT_W-1:0] POS_DEST     = 12'd8;
    localparam logic [COUNT_W-1:0] POS_SRC      = 12'd14;
    localparam logic [COUNT_W-1:0] POS_TL       = 12'd20;
    localparam logic [COUNT_W-1:0] POS_TL_END   = 12'd22;
    localparam logic [COUNT_W-1:0] POS_CRC_FROM = 12'd12;

    localparam logic [7:0] PREAMBLE_BYTE = 8'h55;
    localparam logic [7:0] SFD_BYTE      = 8'hD5;

    localparam logic [31:0] CRC_POLY   = 32'hEDB88320;
    localparam logic [31:0] CRC_PRESET = 32'hFFFFFFFF;

    // Size limits
    localparam logic [COUNT_W-1:0] MIN_BYTES      = 12'd26;
    localparam logic [COUNT_W-1:0] MIN_TYPE_BYTES = 12'd72;
    localparam logic [COUNT_W-1:0] MAX_OK_BYTES   = 12'd1526;
    localparam logic [15:0]        MAX_LEN_FIELD  = 16'd1500;
    localparam logic [15:0]        MIN_ETHERTYPE  = 16'h0600;
    localparam logic [15:0]        MIN_DATA_LEN   = 16'd46;
    localparam logic [10:0]        DFL_SAT        = 11'd2047;

    // Fault codes
    localparam logic [3:0] FAULT_OK       = 4'd0;
    localparam logic [3:0] FAULT_SHORT    = 4'd1;
    localparam logic [3:0] FAULT_PREAMBLE = 4'd2;
    localparam logic [3:0] FAULT_SFD      = 4'd3;
    localparam logic [3:0] FAULT_SIZE     = 4'd4;
    localparam logic [3:0] FAULT_RSVD     = 4'd5;
    localparam logic [3:0] FAULT_TSHORT   = 4'd6;
    localparam logic [3:0] FAULT_LONG     = 4'd7;
    localparam logic [3:0] FAULT_FCS      = 4'd8;

    // EtherType classes
    localparam logic [1:0]  CLASS_UNKNOWN = 2'd0;
    localparam logic [1:0]  CLASS_IPV4    = 2'd1;
    localparam logic [1:0]  CLASS_ARP     = 2'd2;
    localparam logic [1:0]  CLASS_IPV6    = 2'd3;
    localparam logic [15:0] TYPE_IPV4     = 16'h0800;
    localparam logic [15:0] TYPE_ARP      = 16'h0806;
    localparam logic [15:0] TYPE_IPV6     = 16'h86DD;

    localparam logic FORMAT_LEN  = 1'b0;
    localparam logic FORMAT_TYPE = 1'b1;

    // Frame state as it stands after the byte just processed
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               overrun;
        logic [3:0]         first_fault;
        logic [15:0]        type_len;
        logic [47:0]        dest;
        logic [47:0]        src;
        logic [31:0]        fcs;
        logic [31:0]        crc;
    } t_frame_sum;

    typedef struct packed {
        logic               frame_valid;
        logic [3:0]         fault_code;
        logic               frame_format;
        logic [47:0]        dest_address;
        logic [47:0]        source_address;
        logic [15:0]        type_or_len;
        logic [1:0]         ethertype_class;
        logic [10:0]        data_field_len;
        logic [5:0]         pad_len;
        logic [31:0]        frame_check_value;
        logic [COUNT_W-1:0] frame_bytes;
    } t_verdict;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
        end
        return c;
    endfunction

endpackage

// ----- hdl/efc_capture.sv -----
// Input register and per-frame state: byte count, header capture, CRC, tail window.
// Depends on efc_pkg.
module efc_capture #(
    parameter int MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_adv,
    input  logic                  i_take,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_last_byte,
    output logic                  o_done,
    output efc_pkg::t_frame_sum   o_sum
);

    localparam logic [efc_pkg::COUNT_W-1:0] COUNT_CAP =
        efc_pkg::COUNT_W'((MAX_FRAME_BYTES > 4095) ? 4095 : MAX_FRAME_BYTES);

    logic                          r_in_valid;
    logic [7:0]                    r_in_byte;
    logic                          r_in_last;

    logic [efc_pkg::COUNT_W-1:0]   r_pos;
    logic                          r_ovf;
    logic [3:0]                    r_ff;
    logic [15:0]                   r_tl;
    logic [47:0]                   r_dest;
    logic [47:0]                   r_src;
    logic [31:0]                   r_tail;
    logic [31:0]                   r_crc;

    efc_pkg::t_frame_sum           n_sum;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_adv) begin
            r_in_valid <= i_take;
        end
        if (i_adv) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    // State after processing the registered byte
    always_comb begin
        n_sum.count       = r_pos;
        n_sum.overrun     = r_ovf;
        n_sum.first_fault = r_ff;
        n_sum.type_len    = r_tl;
        n_sum.dest        = r_dest;
        n_sum.src         = r_src;
        n_sum.fcs         = {r_in_byte, r_tail[31:8]};
        n_sum.crc         = r_crc;

        priority if (r_pos < efc_pkg::POS_SFD) begin
            if (r_in_byte != efc_pkg::PREAMBLE_BYTE && r_ff == efc_pkg::FAULT_OK) begin
                n_sum.first_fault = efc_pkg::FAULT_PREAMBLE;
            end
        end else if (r_pos == efc_pkg::POS_SFD) begin
            if (r_in_byte != efc_pkg::SFD_BYTE && r_ff == efc_pkg::FAULT_OK) begin
                n_sum.first_fault = efc_pkg::FAULT_SFD;
            end
        end else if (r_pos < efc_pkg::POS_SRC) begin
            n_sum.dest = {r_dest[39:0], r_in_byte};
        end else if (r_pos < efc_pkg::POS_TL) begin
            n_sum.src = {r_src[39:0], r_in_byte};
        end else if (r_pos < efc_pkg::POS_TL_END) begin
            n_sum.type_len = {r_tl[7:0], r_in_byte};
        end else begin
            // data and FCS bytes: nothing captured
        end

        // CRC trails the input by four bytes so the FCS stays out of it
        if (r_pos >= efc_pkg::POS_CRC_FROM) begin
            n_sum.crc = efc_pkg::crc_byte(r_crc, r_tail[7:0]);
        end

        if (r_pos < COUNT_CAP) begin
            n_sum.count = r_pos + 1'b1;
        end else begin
            n_sum.overrun = 1'b1;
        end
    end

    // Frame state; cleared after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && r_in_valid && r_in_last)) begin
            r_pos  <= '0;
            r_ovf  <= 1'b0;
            r_ff   <= efc_pkg::FAULT_OK;
            r_tl   <= '0;
            r_dest <= '0;
            r_src  <= '0;
            r_tail <= '0;
            r_crc  <= efc_pkg::CRC_PRESET;
        end else if (i_adv && r_in_valid) begin
            r_pos  <= n_sum.count;
            r_ovf  <= n_sum.overrun;
            r_ff   <= n_sum.first_fault;
            r_tl   <= n_sum.type_len;
            r_dest <= n_sum.dest;
            r_src  <= n_sum.src;
            r_tail <= n_sum.fcs;
            r_crc  <= n_sum.crc;
        end
    end

    assign o_done = r_in_valid && r_in_last;
    assign o_sum  = n_sum;

endmodule

// ----- hdl/efc_verdict.sv -----
// Verdict logic: fault priority, length fields and EtherType class of a finished frame.
// Depends on efc_pkg.
module efc_verdict (
    input  efc_pkg::t_frame_sum i_sum,
    output efc_pkg::t_verdict   o_verdict
);

    logic                          is_len;
    logic [efc_pkg::COUNT_W-1:0]   cnt_m26;
    logic [10:0]                   dfl;
    logic [5:0]                    pad;
    logic [3:0]                    fault;
    logic [1:0]                    cls;

    // Data field and padding lengths
    always_comb begin
        is_len  = i_sum.type_len <= efc_pkg::MAX_LEN_FIELD;
        cnt_m26 = i_sum.count - efc_pkg::MIN_BYTES;
        pad     = '0;
        if (is_len) begin
            if (i_sum.type_len < efc_pkg::MIN_DATA_LEN) begin
                dfl = efc_pkg::MIN_DATA_LEN[10:0];
                pad = efc_pkg::MIN_DATA_LEN[5:0] - i_sum.type_len[5:0];
            end else begin
                dfl = i_sum.type_len[10:0];
            end
        end else if (i_sum.count < efc_pkg::MIN_BYTES) begin
            dfl = '0;
        end else if (cnt_m26 > {1'b0, efc_pkg::DFL_SAT}) begin
            dfl = efc_pkg::DFL_SAT;
        end else begin
            dfl = cnt_m26[10:0];
        end
    end

    // A short frame wins, then the first recorded fault; FCS checked only on an otherwise clean frame
    always_comb begin
        priority if (i_sum.count < efc_pkg::MIN_BYTES) begin
            fault = efc_pkg::FAULT_SHORT;
        end else if (i_sum.first_fault != efc_pkg::FAULT_OK) begin
            fault = i_sum.first_fault;
        end else if (is_len) begin
            fault = (i_sum.overrun ||
                     i_sum.count != efc_pkg::MIN_BYTES + {1'b0, dfl})
                    ? efc_pkg::FAULT_SIZE : efc_pkg::FAULT_OK;
        end else if (i_sum.type_len < efc_pkg::MIN_ETHERTYPE) begin
            fault = efc_pkg::FAULT_RSVD;
        end else if (i_sum.count < efc_pkg::MIN_TYPE_BYTES) begin
            fault = efc_pkg::FAULT_TSHORT;
        end else if (i_sum.overrun || i_sum.count > efc_pkg::MAX_OK_BYTES) begin
            fault = efc_pkg::FAULT_LONG;
        end else begin
            fault = efc_pkg::FAULT_OK;
        end
        if (fault == efc_pkg::FAULT_OK && ~i_sum.crc != i_sum.fcs) begin
            fault = efc_pkg::FAULT_FCS;
        end
    end

    // EtherType class
    always_comb begin
        priority if (i_sum.type_len == efc_pkg::TYPE_IPV4) begin
            cls = efc_pkg::CLASS_IPV4;
        end else if (i_sum.type_len == efc_pkg::TYPE_ARP) begin
            cls = efc_pkg::CLASS_ARP;
        end else if (i_sum.type_len == efc_pkg::TYPE_IPV6) begin
            cls = efc_pkg::CLASS_IPV6;
        end else begin
            cls = efc_pkg::CLASS_UNKNOWN;
        end
    end

    assign o_verdict.frame_valid       = fault == efc_pkg::FAULT_OK;
    assign o_verdict.fault_code        = fault;
    assign o_verdict.frame_format      = is_len ? efc_pkg::FORMAT_LEN : efc_pkg::FORMAT_TYPE;
    assign o_verdict.dest_address      = i_sum.dest;
    assign o_verdict.source_address    = i_sum.src;
    assign o_verdict.type_or_len       = i_sum.type_len;
    assign o_verdict.ethertype_class   = cls;
    assign o_verdict.data_field_len    = dfl;
    assign o_verdict.pad_len           = pad;
    assign o_verdict.frame_check_value = i_sum.fcs;
    assign o_verdict.frame_bytes       = i_sum.count;

endmodule

// ----- hdl/ethernet_frame_checker.sv -----
// Channel   Direction  Handshake           Payload
// bytes     in         i_valid / o_stall   i_data_byte, i_last_byte
// verdict   out        o_valid / i_stall   o_frame_valid .. o_frame_bytes
//
// One byte request is taken per cycle while o_stall is low. A verdict appears once its last
// byte is accepted: the byte lands in the input register, then the verdict register loads.
// The CRC-32 byte update and the verdict compares sit between them.
// Reset is synchronous, active low, and clears the frame state to a fresh frame.
// While a verdict is held by i_stall the whole pipe holds and o_stall is raised.
//
// Top level of the Ethernet frame checker; depends on efc_pkg, efc_capture,
// efc_verdict and ethernet_frame_checker_assert.svh.
`include "ethernet_frame_checker_assert.svh"

module ethernet_frame_checker #(
    parameter int MAX_FRAME_BYTES = efc_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_frame_valid,
    output logic [3:0]  o_fault_code,
    output logic        o_frame_format,
    output logic [47:0] o_dest_address,
    output logic [47:0] o_source_address,
    output logic [15:0] o_type_or_len,
    output logic [1:0]  o_ethertype_class,
    output logic [10:0] o_data_field_len,
    output logic [5:0]  o_pad_len,
    output logic [31:0] o_frame_check_value,
    output logic [11:0] o_frame_bytes
);

    logic                 adv;
    logic                 done;
    efc_pkg::t_frame_sum  sum;
    efc_pkg::t_verdict    verdict;

    logic                 r_out_valid;
    efc_pkg::t_verdict    r_verdict;

    // Pipe advances unless a held verdict is stalled
    assign adv     = !(r_out_valid && i_stall);
    assign o_stall = !adv;

    efc_capture #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_adv       (adv),
        .i_take      (i_valid),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_done      (done),
        .o_sum       (sum)
    );

    efc_verdict u_verdict (
        .i_sum     (sum),
        .o_verdict (verdict)
    );

    // Verdict register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= done;
        end
        if (adv && done) begin
            r_verdict <= verdict;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_frame_valid       = r_verdict.frame_valid;
    assign o_fault_code        = r_verdict.fault_code;
    assign o_frame_format      = r_verdict.frame_format;
    assign o_dest_address      = r_verdict.dest_address;
    assign o_source_address    = r_verdict.source_address;
    assign o_type_or_len       = r_verdict.type_or_len;
    assign o_ethertype_class   = r_verdict.ethertype_class;
    assign o_data_field_len    = r_verdict.data_field_len;
    assign o_pad_len           = r_verdict.pad_len;
    assign o_frame_check_value = r_verdict.frame_check_value;
    assign o_frame_bytes       = r_verdict.frame_bytes;

    // Checks
    `EFC_ASSERT_IMPL(a_valid_flag, o_valid, o_frame_valid == (o_fault_code == efc_pkg::FAULT_OK))
    `EFC_ASSERT_IMPL(a_pad_len_only, o_valid && o_pad_len != 6'd0, o_frame_format == efc_pkg::FORMAT_LEN && o_data_field_len == 11'd46)
    `EFC_ASSERT_IMPL(a_good_size, o_valid && o_frame_valid, o_frame_bytes >= efc_pkg::MIN_TYPE_BYTES && o_frame_bytes <= efc_pkg::MAX_OK_BYTES)
    `EFC_ASSERT_NEXT(a_stall_holds, o_valid && i_stall, o_valid && $stable(o_fault_code))

endmodule

// ----- bench/tb_top.sv -----
// Testbench for ethernet_frame_checker: sends whole raw frames byte by byte and checks every
// verdict against a behavioral predictor kept in this file.
// Depends on efc_pkg (types and constants) and the ethernet_frame_checker RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int CLK_PERIOD        = 8;
    localparam int COUNT_CAP         = (efc_pkg::MAX_FRAME_BYTES_DEF > 4095)
                                       ? 4095 : efc_pkg::MAX_FRAME_BYTES_DEF;
    localparam int LONG_HOLD_CYCLES  = 120;
    localparam int DRAIN_LIMIT       = 1000;
    localparam int TARGET_BYTES      = 1650;
    localparam int MIN_RANDOM_FRAMES = 6;
    localparam int MAX_PRINTED       = 40;
    localparam int RUN_LIMIT_NS      = 2_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_stall;
    logic        o_frame_valid;
    logic [3:0]  o_fault_code;
    logic        o_frame_format;
    logic [47:0] o_dest_address;
    logic [47:0] o_source_address;
    logic [15:0] o_type_or_len;
    logic [1:0]  o_ethertype_class;
    logic [10:0] o_data_field_len;
    logic [5:0]  o_pad_len;
    logic [31:0] o_frame_check_value;
    logic [11:0] o_frame_bytes;

    // Predicted frame state
    int          fr_pos;
    logic [31:0] fr_crc;
    logic [47:0] fr_dest;
    logic [47:0] fr_src;
    logic [15:0] fr_type_len;
    logic [31:0] fr_tail;
    logic [3:0]  fr_fault;
    logic        fr_overrun;

    efc_pkg::t_verdict pending_verdicts[$];
    logic [7:0]        frame_buf[$];

    bit          feed_gaps_on;
    bit          drain_gaps_on;
    bit          hold_request;
    int          mismatches;
    int          verdicts_checked;
    int          frames_sent;
    int          bytes_sent;
    logic [8:0]  faults_seen;

    ethernet_frame_checker dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_data_byte         (i_data_byte),
        .i_last_byte         (i_last_byte),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_frame_valid       (o_frame_valid),
        .o_fault_code        (o_fault_code),
        .o_frame_format      (o_frame_format),
        .o_dest_address      (o_dest_address),
        .o_source_address    (o_source_address),
        .o_type_or_len       (o_type_or_len),
        .o_ethertype_class   (o_ethertype_class),
        .o_data_field_len    (o_data_field_len),
        .o_pad_len           (o_pad_len),
        .o_frame_check_value (o_frame_check_value),
        .o_frame_bytes       (o_frame_bytes)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Reflected CRC-32 over one byte, LSB first
    function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        repeat (8) c = c[0] ? ((c >> 1) ^ efc_pkg::CRC_POLY) : (c >> 1);
        return c;
    endfunction

    function automatic void clear_frame_state();
        fr_pos      = 0;
        fr_crc      = efc_pkg::CRC_PRESET;
        fr_dest     = '0;
        fr_src      = '0;
        fr_type_len = '0;
        fr_tail     = '0;
        fr_fault    = efc_pkg::FAULT_OK;
        fr_overrun  = 1'b0;
    endfunction

    // Advance the predicted state by one accepted byte; on the last byte queue the verdict
    function automatic void track_byte(input logic [7:0] b, input logic last);
        efc_pkg::t_verdict v;
        int                cnt;
        int                dfl;
        int                pad;
        logic [3:0]        code;
        if (fr_pos < 7) begin
            if (b != efc_pkg::PREAMBLE_BYTE && fr_fault == efc_pkg::FAULT_OK)
                fr_fault = efc_pkg::FAULT_PREAMBLE;
        end else if (fr_pos == 7) begin
            if (b != efc_pkg::SFD_BYTE && fr_fault == efc_pkg::FAULT_OK)
                fr_fault = efc_pkg::FAULT_SFD;
        end else if (fr_pos < 14) begin
            fr_dest = {fr_dest[39:0], b};
        end else if (fr_pos < 20) begin
            fr_src = {fr_src[39:0], b};
        end else if (fr_pos < 22) begin
            fr_type_len = {fr_type_len[7:0], b};
        end
        // CRC runs four bytes behind so the FCS itself stays out of it
        if (fr_pos >= 12) fr_crc = crc32_update(fr_crc, fr_tail[7:0]);
        fr_tail = {b, fr_tail[31:8]};
        if (fr_pos < COUNT_CAP) fr_pos++;
        else fr_overrun = 1'b1;
        if (!last) return;

        cnt = fr_pos;
        if (fr_type_len <= efc_pkg::MAX_LEN_FIELD) begin
            dfl = (int'(fr_type_len) < int'(efc_pkg::MIN_DATA_LEN))
                  ? int'(efc_pkg::MIN_DATA_LEN) : int'(fr_type_len);
            pad = dfl - int'(fr_type_len);
        end else begin
            dfl = (cnt >= int'(efc_pkg::MIN_BYTES)) ? cnt - int'(efc_pkg::MIN_BYTES) : 0;
            if (dfl > int'(efc_pkg::DFL_SAT)) dfl = int'(efc_pkg::DFL_SAT);
            pad = 0;
        end

        // First fault in priority order
        if (cnt < int'(efc_pkg::MIN_BYTES)) code = efc_pkg::FAULT_SHORT;
        else if (fr_fault != efc_pkg::FAULT_OK) code = fr_fault;
        else if (fr_type_len <= efc_pkg::MAX_LEN_FIELD)
            code = (fr_overrun || cnt != int'(efc_pkg::MIN_BYTES) + dfl)
                   ? efc_pkg::FAULT_SIZE : efc_pkg::FAULT_OK;
        else if (fr_type_len < efc_pkg::MIN_ETHERTYPE) code = efc_pkg::FAULT_RSVD;
        else if (cnt < int'(efc_pkg::MIN_TYPE_BYTES)) code = efc_pkg::FAULT_TSHORT;
        else if (fr_overrun || cnt > int'(efc_pkg::MAX_OK_BYTES)) code = efc_pkg::FAULT_LONG;
        else code = efc_pkg::FAULT_OK;
        if (code == efc_pkg::FAULT_OK && ~fr_crc != fr_tail) code = efc_pkg::FAULT_FCS;

        v.frame_valid       = (code == efc_pkg::FAULT_OK);
        v.fault_code        = code;
        v.frame_format      = (fr_type_len > efc_pkg::MAX_LEN_FIELD)
                              ? efc_pkg::FORMAT_TYPE : efc_pkg::FORMAT_LEN;
        v.dest_address      = fr_dest;
        v.source_address    = fr_src;
        v.type_or_len       = fr_type_len;
        case (fr_type_len)
            efc_pkg::TYPE_IPV4: v.ethertype_class = efc_pkg::CLASS_IPV4;
            efc_pkg::TYPE_ARP:  v.ethertype_class = efc_pkg::CLASS_ARP;
            efc_pkg::TYPE_IPV6: v.ethertype_class = efc_pkg::CLASS_IPV6;
            default:            v.ethertype_class = efc_pkg::CLASS_UNKNOWN;
        endcase
        v.data_field_len    = 11'(dfl);
        v.pad_len           = 6'(pad);
        v.frame_check_value = fr_tail;
        v.frame_bytes       = 12'(cnt);
        pending_verdicts.push_back(v);
        clear_frame_state();
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("MISMATCH at verdict %0d, %s: got %0h, expected %0h",
                     verdicts_checked, what, got, want);
    endtask

    // Compare an accepted verdict with the oldest prediction
    task automatic check_verdict();
        efc_pkg::t_verdict exp_v;
        if (pending_verdicts.size() == 0) begin
            report_mismatch("verdict with none pending", 1, 0);
            return;
        end
        exp_v = pending_verdicts.pop_front();
        faults_seen[exp_v.fault_code] = 1'b1;
        if (o_frame_valid !== exp_v.frame_valid)
            report_mismatch("frame_valid", o_frame_valid, exp_v.frame_valid);
        if (o_fault_code !== exp_v.fault_code)
            report_mismatch("fault_code", o_fault_code, exp_v.fault_code);
        if (o_frame_format !== exp_v.frame_format)
            report_mismatch("frame_format", o_frame_format, exp_v.frame_format);
        if (o_dest_address !== exp_v.dest_address)
            report_mismatch("dest_address", o_dest_address, exp_v.dest_address);
        if (o_source_address !== exp_v.source_address)
            report_mismatch("source_address", o_source_address, exp_v.source_address);
        if (o_type_or_len !== exp_v.type_or_len)
            report_mismatch("type_or_len", o_type_or_len, exp_v.type_or_len);
        if (o_ethertype_class !== exp_v.ethertype_class)
            report_mismatch("ethertype_class", o_ethertype_class, exp_v.ethertype_class);
        if (o_data_field_len !== exp_v.data_field_len)
            report_mismatch("data_field_len", o_data_field_len, exp_v.data_field_len);
        if (o_pad_len !== exp_v.pad_len)
            report_mismatch("pad_len", o_pad_len, exp_v.pad_len);
        if (o_frame_check_value !== exp_v.frame_check_value)
            report_mismatch("frame_check_value", o_frame_check_value, exp_v.frame_check_value);
        if (o_frame_bytes !== exp_v.frame_bytes)
            report_mismatch("frame_bytes", o_frame_bytes, exp_v.frame_bytes);
        verdicts_checked++;
    endtask

    // Verdict side: random stall stretches, each followed by an open cycle,
    // or one long hold when a test asks for it
    initial begin : verdict_sink
        int gap;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD_CYCLES;
            end else begin
                gap = drain_gaps_on ? $urandom_range(0, 11) : 0;
            end
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            @(posedge i_clk);
            if (o_valid === 1'b1 && i_stall === 1'b0) check_verdict();
        end
    end

    // Offer one byte request, holding it until the block takes it
    task automatic offer_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = feed_gaps_on ? $urandom_range(0, 11) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid     <= 1'b0;
            i_data_byte <= 8'($urandom);
            i_last_byte <= 1'($urandom);
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        track_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            offer_byte(frame_buf[i], i == frame_buf.size() - 1);
        frames_sent++;
    endtask

    // Stop sending and wait for every predicted verdict, with a bound
    task automatic drain_verdicts();
        int waited;
        @(negedge i_clk);
        i_valid <= 1'b0;
        waited = 0;
        while (pending_verdicts.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (pending_verdicts.size() != 0) begin
            report_mismatch("verdicts never delivered", 0, pending_verdicts.size());
            pending_verdicts.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    // Preamble, SFD, header, data and a FCS that is right unless fcs_ok is clear
    task automatic build_frame(input logic [47:0] da, input logic [47:0] sa,
                               input logic [15:0] tl, input int data_len, input bit fcs_ok);
        logic [31:0] crc;
        frame_buf.delete();
        repeat (7) frame_buf.push_back(efc_pkg::PREAMBLE_BYTE);
        frame_buf.push_back(efc_pkg::SFD_BYTE);
        for (int i = 5; i >= 0; i--) frame_buf.push_back(da[8*i +: 8]);
        for (int i = 5; i >= 0; i--) frame_buf.push_back(sa[8*i +: 8]);
        frame_buf.push_back(tl[15:8]);
        frame_buf.push_back(tl[7:0]);
        repeat (data_len) frame_buf.push_back(8'($urandom));
        crc = efc_pkg::CRC_PRESET;
        for (int i = 8; i < frame_buf.size(); i++) crc = crc32_update(crc, frame_buf[i]);
        crc = ~crc;
        if (!fcs_ok) crc ^= 32'(1) << $urandom_range(0, 31);
        for (int i = 0; i < 4; i++) frame_buf.push_back(crc[8*i +: 8]);
    endtask

    function automatic logic [47:0] pick_address();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [15:0] pick_ethertype();
        case ($urandom_range(0, 3))
            0:       return efc_pkg::TYPE_IPV4;
            1:       return efc_pkg::TYPE_ARP;
            2:       return efc_pkg::TYPE_IPV6;
            default: return 16'($urandom_range(int'(efc_pkg::MIN_ETHERTYPE), 16'hFFFF));
        endcase
    endfunction

    // Mostly short length fields, now and then a longer one
    function automatic logic [15:0] pick_length();
        return ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 600))
                                            : 16'($urandom_range(0, 100));
    endfunction

    function automatic int padded_len(input logic [15:0] len);
        return (len < efc_pkg::MIN_DATA_LEN) ? int'(efc_pkg::MIN_DATA_LEN) : int'(len);
    endfunction

    // One random frame: mostly well formed, the rest with one fault or plain noise
    task automatic random_frame();
        logic [47:0] da;
        logic [47:0] sa;
        logic [15:0] tl;
        int          kind;
        int          dlen;
        int          cut;
        da   = pick_address();
        sa   = pick_address();
        tl   = pick_ethertype();
        dlen = $urandom_range(46, 80);
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            build_frame(da, sa, tl, dlen, 1'b1);
        end else if (kind < 55) begin
            tl = pick_length();
            build_frame(da, sa, tl, padded_len(tl), 1'b1);
        end else if (kind < 63) begin
            if ($urandom_range(0, 1)) begin
                tl   = pick_length();
                dlen = padded_len(tl);
            end
            build_frame(da, sa, tl, dlen, 1'b0);
        end else if (kind < 68) begin
            build_frame(da, sa, tl, dlen, 1'b1);
            frame_buf[$urandom_range(0, 6)] ^= 8'($urandom_range(1, 255));
        end else if (kind < 72) begin
            build_frame(da, sa, tl, dlen, 1'b1);
            frame_buf[7] ^= 8'($urandom_range(1, 255));
        end else if (kind < 78) begin
            // length frame one to eight bytes off its size
            tl  = pick_length();
            cut = $urandom_range(1, 8);
            build_frame(da, sa, tl, padded_len(tl) + ($urandom_range(0, 1) ? cut : -cut), 1'b1);
        end else if (kind < 82) begin
            build_frame(da, sa, 16'($urandom_range(1501, int'(efc_pkg::MIN_ETHERTYPE) - 1)),
                        dlen, 1'b1);
        end else if (kind < 87) begin
            build_frame(da, sa, tl, $urandom_range(0, 45), 1'b1);
        end else if ($urandom_range(0, 1)) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
        end else begin
            build_frame(da, sa, tl, dlen, 1'b1);
            cut = $urandom_range(1, 30);
            frame_buf = frame_buf[0:cut-1];
        end
    endtask

    // Legal minimum-size frames and every known type, the last ones at line rate
    task automatic test_good_frames();
        feed_gaps_on = 1'b1;
        build_frame('0, '1, 16'd0, 46, 1'b1);
        send_frame();
        build_frame('1, '0, 16'd45, 46, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), 16'd46, 46, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_IPV4, 46, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_ARP, 60, 1'b1);
        send_frame();
        feed_gaps_on = 1'b0;
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_IPV6, 80, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), efc_pkg::MIN_ETHERTYPE, 46, 1'b1);
        send_frame();
        feed_gaps_on = 1'b1;
        drain_verdicts();
    endtask

    // Preamble, SFD and FCS faults, alone and stacked
    task automatic test_header_faults();
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_IPV4, 50, 1'b1);
        frame_buf[0] = 8'h00;
        send_frame();
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_IPV4, 50, 1'b1);
        frame_buf[6] ^= 8'h80;
        send_frame();
        build_frame(pick_address(), pick_address(), 16'd60, 60, 1'b1);
        frame_buf[3] = 8'hAA;
        frame_buf[7] = efc_pkg::PREAMBLE_BYTE;
        send_frame();
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_ARP, 46, 1'b1);
        frame_buf[7] = 8'hD4;
        send_frame();
        // short wins over a bad SFD
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_ARP, 46, 1'b1);
        frame_buf[7] = 8'hFF;
        frame_buf = frame_buf[0:19];
        send_frame();
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_IPV6, 64, 1'b0);
        send_frame();
        build_frame(pick_address(), pick_address(), 16'd30, 46, 1'b0);
        send_frame();
        drain_verdicts();
    endtask

    // Short, size mismatch, reserved type and short type frame
    task automatic test_size_faults();
        frame_buf.delete();
        frame_buf.push_back(efc_pkg::PREAMBLE_BYTE);
        send_frame();
        build_frame(pick_address(), pick_address(), 16'd0, 0, 1'b1);
        frame_buf = frame_buf[0:24];
        send_frame();
        build_frame(pick_address(), pick_address(), 16'd0, 0, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), 16'd100, 101, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), 16'd60, 59, 1'b1);
        send_frame();
        // length below 46 but sent without padding
        build_frame(pick_address(), pick_address(), 16'd10, 10, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), 16'h05DD, 46, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), 16'h05FF, 46, 1'b1);
        send_frame();
        build_frame(pick_address(), pick_address(), efc_pkg::TYPE_IPV4, 45, 1'b1);
        send_frame();
        drain_verdicts();
    endtask

    // Long receiver hold while back-to-back frames keep coming, so the pipe fills
    task automatic test_backpressure();
        feed_gaps_on = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (i % 8 == 7) begin
                build_frame(pick_address(), pick_address(), efc_pkg::TYPE_IPV4, 46, 1'b1);
            end else begin
                frame_buf.delete();
                repeat ($urandom_range(1, 3)) frame_buf.push_back(8'($urandom));
            end
            send_frame();
        end
        drain_verdicts();
        feed_gaps_on = 1'b1;
    endtask

    // Random frames in stretches with and without gaps on either side
    task automatic test_random_traffic();
        int n;
        n = 0;
        while (bytes_sent < TARGET_BYTES || n < MIN_RANDOM_FRAMES) begin
            if (n % 12 == 0) begin
                feed_gaps_on  = ($urandom_range(0, 3) != 0);
                drain_gaps_on = ($urandom_range(0, 3) != 0);
            end
            random_frame();
            send_frame();
            n++;
            if ($urandom_range(0, 19) == 0) drain_verdicts();
        end
        drain_verdicts();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_data_byte      = '0;
        i_last_byte      = 1'b0;
        feed_gaps_on     = 1'b1;
        drain_gaps_on    = 1'b1;
        hold_request     = 1'b0;
        mismatches       = 0;
        verdicts_checked = 0;
        frames_sent      = 0;
        bytes_sent       = 0;
        faults_seen      = '0;
        clear_frame_state();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_good_frames();
        test_header_faults();
        test_size_faults();
        test_backpressure();
        test_random_traffic();

        $display("Run: %0d frames, %0d bytes, %0d verdicts checked, with a long receiver hold",
                 frames_sent, bytes_sent, verdicts_checked);
        $display("Fault codes reached (code 8 down to 0): %b", faults_seen);
        if (mismatches == 0) begin
            $display("** ethernet_frame_checker: PASSED **");
        end else begin
            $display("** ethernet_frame_checker: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(RUN_LIMIT_NS);
        $display("Timeout after %0d ns", RUN_LIMIT_NS);
        $display("** ethernet_frame_checker: FAILED **");
        $finish;
    end

endmodule
